>>> src/pcfr_pkg.sv
`timescale 1ns / 1ps
package pcfr_pkg;

  localparam int FRAME_COUNT_DEF = 64;

  localparam int OP_W     = 3;
  localparam int PHYS_W   = 44;
  localparam int VIRT_W   = 27;
  localparam int PRIO_W   = 2;
  localparam int FIDX_W   = 6;
  localparam int STATUS_W = 2;
  localparam int RIDX_W   = 6;
  localparam int USED_W   = 7;

  localparam logic [PRIO_W-1:0] TOP_PRIO = 2'd3;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_ACCESS  = 3'd2,
    OP_CHOOSE  = 3'd3,
    OP_RELEASE = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_NOVICTIM = 2'd3
  } status_t;

  // One finished result, handed from the sequencer to the output stage
  typedef struct packed {
    status_t             status;
    logic [RIDX_W-1:0]   index;
    logic [PHYS_W-1:0]   phys;
    logic [VIRT_W-1:0]   virt;
  } res_t;

endpackage

>>> src/pcfr_ram.sv
`timescale 1ns / 1ps
module pcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/pcfr_ctrl.sv
`timescale 1ns / 1ps
module pcfr_ctrl #(
  parameter int FRAME_COUNT = pcfr_pkg::FRAME_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pcfr_pkg::OP_W-1:0]   op_i,
  input  logic [pcfr_pkg::PHYS_W-1:0] phys_i,
  input  logic [pcfr_pkg::VIRT_W-1:0] virt_i,
  input  logic [pcfr_pkg::PRIO_W-1:0] prio_i,
  input  logic [pcfr_pkg::FIDX_W-1:0] fidx_i,
  input  logic                        out_free,
  output logic                        busy,
  output logic                        res_valid,
  output pcfr_pkg::res_t              res,
  output logic [pcfr_pkg::USED_W-1:0] used
);
  import pcfr_pkg::*;

  localparam int IDX_W   = $clog2(FRAME_COUNT);
  localparam int CNT_W   = $clog2(2 * FRAME_COUNT + 1);
  localparam int UC_W    = $clog2(FRAME_COUNT + 1);
  localparam int ENTRY_W = PHYS_W + VIRT_W + PRIO_W;
  localparam logic [CNT_W-1:0] ONE_PASS = CNT_W'(FRAME_COUNT);
  localparam logic [CNT_W-1:0] TWO_PASS = CNT_W'(2 * FRAME_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t                 state_r;
  op_t                    op_r;
  logic [PHYS_W-1:0]      pa_r;
  logic [VIRT_W-1:0]      va_r;
  logic [PRIO_W-1:0]      prio_r;
  logic [FRAME_COUNT-1:0] valid_r, swap_r, acc_r;
  logic [IDX_W-1:0]       hand_r, idx_r, cmp_idx_r, best_r;
  logic [CNT_W-1:0]       iss_cnt_r, cmp_cnt_r;
  logic                   cmp_vld_r, found_r;
  logic [PRIO_W-1:0]      keep_prio_r;
  logic [PHYS_W-1:0]      best_phys_r;
  logic [VIRT_W-1:0]      best_virt_r;
  logic [UC_W-1:0]        count_r;
  res_t                   res_r;

  logic [ENTRY_W-1:0] rd_data;
  logic [PHYS_W-1:0]  rd_phys;
  logic [VIRT_W-1:0]  rd_virt;
  logic [PRIO_W-1:0]  rd_prio;
  logic               act, ev, es, ea, phys_eq, is_choose, hit, cand, found_n;
  logic [IDX_W-1:0]   best_n;
  logic [CNT_W-1:0]   cmp_cnt_n, scan_limit;
  logic               victim_now, exhausted, fin_hit, fin_vict, fin_none;
  logic               ram_we, fidx_ok;
  logic [IDX_W-1:0]   fidx;

  assign {rd_phys, rd_virt, rd_prio} = rd_data;

  pcfr_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(FRAME_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cmp_idx_r),
    .wdata({pa_r, va_r, prio_r}),
    .raddr(idx_r),
    .rdata(rd_data)
  );

  // Compare stage: entry cmp_idx_r with its RAM data
  always_comb begin
    act        = (state_r == S_SCAN) && cmp_vld_r;
    ev         = valid_r[cmp_idx_r];
    es         = swap_r[cmp_idx_r];
    ea         = acc_r[cmp_idx_r];
    phys_eq    = (rd_phys == pa_r);
    is_choose  = (op_r == OP_CHOOSE);
    scan_limit = is_choose ? TWO_PASS : ONE_PASS;
    case (op_r)
      OP_ALLOC:  hit = !ev;
      OP_REMOVE: hit = ev && phys_eq && !es;
      OP_ACCESS: hit = ev && phys_eq;
      default:   hit = 1'b0;
    endcase
    cand       = is_choose && ev && !es && !ea && (!found_r || rd_prio >= keep_prio_r);
    found_n    = found_r || cand;
    best_n     = cand ? cmp_idx_r : best_r;
    cmp_cnt_n  = cmp_cnt_r + 1'b1;
    exhausted  = (cmp_cnt_n == scan_limit);
    // a victim is taken on top priority or at the end of either pass
    victim_now = (cand && rd_prio == TOP_PRIO) ||
                 (is_choose && found_n && (cmp_cnt_n == ONE_PASS || exhausted));
    fin_hit    = act && hit;
    fin_vict   = act && victim_now;
    fin_none   = act && !hit && !victim_now && exhausted;
    ram_we     = act && (op_r == OP_ALLOC) && !ev;
    fidx_ok    = (32'(fidx_i) < FRAME_COUNT);
    fidx       = IDX_W'(fidx_i);
  end

  // Sequencer and entry flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      swap_r    <= '0;
      acc_r     <= '0;
      hand_r    <= '0;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmp_vld_r <= 1'b0;
            found_r   <= 1'b0;
            iss_cnt_r <= '0;
            cmp_cnt_r <= '0;
            idx_r     <= (op_i == OP_CHOOSE) ? hand_r : '0;
            case (op_i)
              OP_ALLOC, OP_REMOVE, OP_ACCESS, OP_CHOOSE: state_r <= S_SCAN;
              OP_RELEASE: begin
                state_r <= S_FINISH;
                if (fidx_ok) begin
                  valid_r[fidx] <= 1'b0;
                  swap_r[fidx]  <= 1'b0;
                  if (valid_r[fidx]) begin
                    count_r <= count_r - 1'b1;
                  end
                end
              end
              default: state_r <= S_FINISH;
            endcase
          end
        end
        S_SCAN: begin
          // issue next read
          if (iss_cnt_r != scan_limit) begin
            iss_cnt_r <= iss_cnt_r + 1'b1;
            cmp_idx_r <= idx_r;
            cmp_vld_r <= 1'b1;
            idx_r     <= (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
          end else begin
            cmp_vld_r <= 1'b0;
          end
          if (act) begin
            cmp_cnt_r <= cmp_cnt_n;
            found_r   <= found_n;
            // second chance: clear a set accessed bit
            if (is_choose && ev && !es && ea) begin
              acc_r[cmp_idx_r] <= 1'b0;
            end
            if (fin_hit) begin
              state_r <= S_FINISH;
              case (op_r)
                OP_ALLOC: begin
                  valid_r[cmp_idx_r] <= 1'b1;
                  swap_r[cmp_idx_r]  <= 1'b0;
                  acc_r[cmp_idx_r]   <= 1'b0;
                  count_r            <= count_r + 1'b1;
                end
                OP_REMOVE: begin
                  valid_r[cmp_idx_r] <= 1'b0;
                  count_r            <= count_r - 1'b1;
                end
                default: acc_r[cmp_idx_r] <= 1'b1;
              endcase
            end else if (fin_vict) begin
              state_r        <= S_FINISH;
              swap_r[best_n] <= 1'b1;
              hand_r         <= (best_n == LAST_IDX) ? '0 : best_n + 1'b1;
            end else if (fin_none) begin
              state_r <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Operands, best candidate and result
  always_ff @(posedge clk) begin
    if (start) begin
      op_r         <= op_t'(op_i);
      pa_r         <= phys_i;
      va_r         <= virt_i;
      prio_r       <= prio_i;
      res_r.status <= (op_i == OP_RELEASE && !fidx_ok) ? ST_NOTFOUND : ST_OK;
      res_r.index  <= (op_i == OP_RELEASE && fidx_ok) ? fidx_i : '0;
      res_r.phys   <= '0;
      res_r.virt   <= '0;
    end
    if (act && cand) begin
      best_r      <= cmp_idx_r;
      keep_prio_r <= rd_prio;
      best_phys_r <= rd_phys;
      best_virt_r <= rd_virt;
    end
    if (fin_hit) begin
      res_r.index <= RIDX_W'(cmp_idx_r);
    end else if (fin_vict) begin
      res_r.index <= RIDX_W'(best_n);
      res_r.phys  <= cand ? rd_phys : best_phys_r;
      res_r.virt  <= cand ? rd_virt : best_virt_r;
    end else if (fin_none) begin
      case (op_r)
        OP_ALLOC:  res_r.status <= ST_FULL;
        OP_CHOOSE: res_r.status <= ST_NOVICTIM;
        default:   res_r.status <= ST_NOTFOUND;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = (state_r == S_FINISH) && out_free;
  assign res       = res_r;
  assign used      = USED_W'(count_r);

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(count_r))
    else $error("used count out of step with valid bits");

  a_hand_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(hand_r) < FRAME_COUNT)
    else $error("hand out of range");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy)
    else $error("accepted item did not occupy the sequencer");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> !busy)
    else $error("sequencer not idle after result transfer");

endmodule

>>> src/priority_clock_frame_replacer_top.sv
`timescale 1ns / 1ps
// Frame table with a priority second-chance clock hand. One operation is
// taken at a time: release and unknown codes finish without a table walk;
// allocate, remove and mark accessed walk the table at most once; choose
// victim walks it at most twice. The walk goes through the entry RAM's
// single read port, which the sequencer reads one entry per cycle. A
// finished result sits in an output register, so a new item may be
// accepted while the previous result still waits to be taken.
module priority_clock_frame_replacer_top #(
  parameter int FRAME_COUNT = pcfr_pkg::FRAME_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pcfr_pkg::OP_W-1:0]       in_operation,
  input  logic [pcfr_pkg::PHYS_W-1:0]     in_phys_page,
  input  logic [pcfr_pkg::VIRT_W-1:0]     in_virt_page,
  input  logic [pcfr_pkg::PRIO_W-1:0]     in_owner_priority,
  input  logic [pcfr_pkg::FIDX_W-1:0]     in_frame_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pcfr_pkg::STATUS_W-1:0]   out_status,
  output logic [pcfr_pkg::RIDX_W-1:0]     out_result_index,
  output logic [pcfr_pkg::PHYS_W-1:0]     out_victim_phys_page,
  output logic [pcfr_pkg::VIRT_W-1:0]     out_victim_virt_page,
  output logic [pcfr_pkg::USED_W-1:0]     out_used_count
);
  import pcfr_pkg::*;

  logic              busy, res_valid, out_free, out_valid_r;
  res_t              res, res_out_r;
  logic [USED_W-1:0] used, used_out_r;

  assign in_stall = busy;
  assign out_free = !out_valid_r || !out_stall;

  pcfr_ctrl #(
    .FRAME_COUNT(FRAME_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_valid && !busy),
    .op_i     (in_operation),
    .phys_i   (in_phys_page),
    .virt_i   (in_virt_page),
    .prio_i   (in_owner_priority),
    .fidx_i   (in_frame_index),
    .out_free (out_free),
    .busy     (busy),
    .res_valid(res_valid),
    .res      (res),
    .used     (used)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_out_r  <= res;
      used_out_r <= used;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = res_out_r.status;
  assign out_result_index     = res_out_r.index;
  assign out_victim_phys_page = res_out_r.phys;
  assign out_victim_virt_page = res_out_r.virt;
  assign out_used_count       = used_out_r;

endmodule
